@@ design/plr_pkg.sv @@
// Shared types, codes and widths of the piecewise linear resampler.
package plr_pkg;

	localparam int WL_W   = 16;              // wavelength, unsigned Q12.4
	localparam int VAL_W  = 24;              // value, signed Q4.20
	localparam int DV_W   = VAL_W + 1;       // value difference and its magnitude
	localparam int PROD_W = WL_W + DV_W;     // dt * |dv|
	localparam int QUO_W  = DV_W;            // quotient never exceeds |dv|
	localparam int MEM_W  = WL_W + VAL_W;    // one table row: {value, wavelength}

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} plr_stat_t;

	typedef enum logic [1:0] {
		RD_ZERO = 2'd0,
		RD_LAST = 2'd1,
		RD_J    = 2'd2,
		RD_K    = 2'd3
	} plr_rd_t;

	typedef enum logic [1:0] {
		RES_ZERO   = 2'd0,
		RES_LO     = 2'd1,
		RES_INTERP = 2'd2
	} plr_res_t;

	// controller -> datapath
	typedef struct packed {
		logic      take_in;
		logic      clear;
		logic      append;
		logic      rd_en;
		plr_rd_t   rd_sel;
		logic      cap_lo;
		logic      cap_hi;
		logic      j_start;
		logic      j_zero;
		logic      j_inc;
		logic      save_search;
		logic      prep;
		logic      mul;
		logic      div_start;
		logic      emit;
		plr_res_t  res_sel;
		plr_stat_t stat;
	} plr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] act;
		logic       empty;
		logic       full;
		logic       t_le_rd;
		logic       t_ge_rd;
		logic       lo_gt_t;
		logic       k_lt_n;
		logic       div_busy;
		logic       out_free;
	} plr_sts_t;

endpackage

@@ design/plr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the interpolation step.
module plr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [plr_pkg::PROD_W-1:0] num,
	input  logic [plr_pkg::WL_W-1:0]   den,
	output logic                      busy,
	output logic [plr_pkg::QUO_W-1:0]  quot
);
	import plr_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] num_q;
	logic [WL_W-1:0]   rem_q;
	logic [QUO_W-1:0]  quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [WL_W:0]     trial;
	logic              fits;

	assign trial = {rem_q, num_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[PROD_W-2:0], 1'b0};
			rem_q  <= fits ? WL_W'(trial - {1'b0, den}) : trial[WL_W-1:0];
			quot_q <= {quot_q[QUO_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

@@ design/plr_dp.sv @@
// Datapath: point table, search pointer, bracket registers, multiply, divide, result register.
module plr_dp #(
	parameter int MAX_POINTS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plr_pkg::plr_cmd_t             cmd,
	output plr_pkg::plr_sts_t             sts,
	input  logic [1:0]                    in_action,
	input  logic [plr_pkg::WL_W-1:0]      in_wl,
	input  logic [plr_pkg::VAL_W-1:0]     in_val,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [plr_pkg::VAL_W-1:0]     out_value,
	output logic [1:0]                    out_status
);
	import plr_pkg::*;

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// latched request
	logic [1:0]       act_q;
	logic [WL_W-1:0]  t_q;
	logic [VAL_W-1:0] sv_q;

	// table and pointers
	logic [MEM_W-1:0] mem_q [MAX_POINTS];
	logic [MEM_W-1:0] rdata_q;
	logic [IW-1:0]    rd_addr;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    search_q;
	logic [IW-1:0]    j_q;

	// bracket
	logic [WL_W-1:0]  lo_w_q, hi_w_q;
	logic [VAL_W-1:0] lo_v_q, hi_v_q;

	// arithmetic
	logic [WL_W-1:0]   dt_q, dw_q;
	logic [DV_W-1:0]   mag_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;
	logic [QUO_W-1:0]  quot;
	logic              div_busy;

	// result register
	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic [1:0]       out_status_q;

	logic [WL_W-1:0]  rd_w;
	logic [VAL_W-1:0] rd_v;
	logic [DV_W-1:0]  dv;
	logic [QUO_W:0]   q_signed;
	logic [VAL_W+2:0] sum;
	logic [VAL_W-1:0] interp;
	logic [VAL_W-1:0] res_value;
	logic [CW-1:0]    k_ext;

	assign rd_w  = rdata_q[WL_W-1:0];
	assign rd_v  = rdata_q[MEM_W-1:WL_W];
	assign k_ext = CW'(j_q) + 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_LAST: rd_addr = IW'(count_q - 1'b1);
			RD_J:    rd_addr = j_q;
			default: rd_addr = IW'(k_ext);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.append)
			mem_q[IW'(count_q)] <= {sv_q, t_q};
		if (cmd.rd_en)
			rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			search_q <= '0;
			j_q      <= '0;
		end else begin
			if (cmd.clear) begin
				count_q  <= '0;
				search_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.save_search) begin
				search_q <= j_q;
			end
			if (cmd.j_start)
				j_q <= (CW'(search_q) < count_q) ? search_q : '0;
			else if (cmd.j_zero)
				j_q <= '0;
			else if (cmd.j_inc)
				j_q <= IW'(k_ext);
		end
	end

	assign dv = DV_W'($signed(hi_v_q)) - DV_W'($signed(lo_v_q));

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			act_q <= in_action;
			t_q   <= in_wl;
			sv_q  <= in_val;
		end
		if (cmd.cap_lo) begin
			lo_w_q <= rd_w;
			lo_v_q <= rd_v;
		end
		if (cmd.cap_hi) begin
			hi_w_q <= rd_w;
			hi_v_q <= rd_v;
		end
		if (cmd.prep) begin
			dt_q  <= t_q - lo_w_q;
			dw_q  <= hi_w_q - lo_w_q;
			neg_q <= dv[DV_W-1];
			mag_q <= dv[DV_W-1] ? (~dv + 1'b1) : dv;
		end
		if (cmd.mul)
			prod_q <= PROD_W'(dt_q) * PROD_W'(mag_q);
	end

	plr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (dw_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	// The bracket keeps the sum between its two values; clamp anyway.
	assign q_signed = neg_q ? (~{1'b0, quot} + 1'b1) : {1'b0, quot};
	assign sum      = (VAL_W+3)'($signed(lo_v_q)) + (VAL_W+3)'($signed(q_signed));

	always_comb begin
		if ($signed(sum) > $signed((VAL_W+3)'({1'b0, {(VAL_W-1){1'b1}}})))
			interp = {1'b0, {(VAL_W-1){1'b1}}};
		else if ($signed(sum) < $signed({{4{1'b1}}, {(VAL_W-1){1'b0}}}))
			interp = {1'b1, {(VAL_W-1){1'b0}}};
		else
			interp = sum[VAL_W-1:0];
	end

	always_comb begin
		case (cmd.res_sel)
			RES_LO:     res_value = lo_v_q;
			RES_INTERP: res_value = interp;
			default:    res_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q  <= res_value;
			out_status_q <= cmd.stat;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	assign sts.act      = act_q;
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CW'(MAX_POINTS));
	assign sts.t_le_rd  = (t_q <= rd_w);
	assign sts.t_ge_rd  = (t_q >= rd_w);
	assign sts.lo_gt_t  = (lo_w_q > t_q);
	assign sts.k_lt_n   = (k_ext < count_q);
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

@@ design/plr_ctrl.sv @@
// Controller: sequences table updates, the clamp checks, the pointer walk and the divide.
module plr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  plr_pkg::plr_sts_t sts,
	output plr_pkg::plr_cmd_t cmd
);
	import plr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_Q_FIRST,
		S_Q_LAST,
		S_J_RD,
		S_J_GOT,
		S_STEP,
		S_K_GOT,
		S_CHECK,
		S_MUL,
		S_DIV,
		S_DWAIT,
		S_FINISH
	} state_t;

	state_t    state_q, state_d;
	plr_res_t  res_q, res_d;
	plr_stat_t stat_q, stat_d;
	logic      retry_q, retry_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		res_d    = res_q;
		stat_d   = stat_q;
		retry_d  = retry_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.take_in = in_valid;
				if (in_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				res_d   = RES_ZERO;
				stat_d  = STAT_OK;
				state_d = S_FINISH;
				unique case (sts.act)
					ACT_CLEAR: cmd.clear = 1'b1;
					ACT_APPEND: begin
						if (sts.full)
							stat_d = STAT_FULL;
						else
							cmd.append = 1'b1;
					end
					ACT_QUERY: begin
						if (sts.empty) begin
							stat_d = STAT_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ZERO;
							state_d    = S_Q_FIRST;
						end
					end
					default: ;
				endcase
			end
			S_Q_FIRST: begin
				cmd.cap_lo = 1'b1;
				if (sts.t_le_rd) begin
					res_d   = RES_LO;
					state_d = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LAST;
					state_d    = S_Q_LAST;
				end
			end
			S_Q_LAST: begin
				cmd.cap_lo = 1'b1;
				if (sts.t_ge_rd) begin
					res_d   = RES_LO;
					state_d = S_FINISH;
				end else begin
					cmd.j_start = 1'b1;
					retry_d     = 1'b0;
					state_d     = S_J_RD;
				end
			end
			S_J_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_J;
				state_d    = S_J_GOT;
			end
			S_J_GOT: begin
				cmd.cap_lo = 1'b1;
				state_d    = S_STEP;
			end
			S_STEP: begin
				if (sts.k_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_K;
					state_d    = S_K_GOT;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_K_GOT: begin
				if (sts.t_ge_rd) begin
					// advance: the upper point becomes the lower one
					cmd.j_inc  = 1'b1;
					cmd.cap_lo = 1'b1;
					state_d    = S_STEP;
				end else begin
					cmd.cap_hi = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if ((!sts.k_lt_n || sts.lo_gt_t) && !retry_q) begin
					// overshot: restart the walk from the first point
					cmd.j_zero = 1'b1;
					retry_d    = 1'b1;
					state_d    = S_J_RD;
				end else begin
					cmd.save_search = 1'b1;
					cmd.prep        = 1'b1;
					state_d         = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (!sts.div_busy) begin
					res_d   = RES_INTERP;
					stat_d  = STAT_OK;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.res_sel = res_q;
				cmd.stat    = stat_q;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_ZERO;
			stat_q  <= STAT_OK;
			retry_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			stat_q  <= stat_d;
			retry_q <= retry_d;
		end
	end

endmodule

@@ design/piecewise_linear_resampler_core.sv @@
// Top level of the piecewise linear resampler: stream ports, controller and datapath.
//
// Piecewise linear resampler with clamped ends. Each request on the slave
// stream is a clear, an append of one source point (wavelength, value) or a
// query at a target wavelength, and every request gives exactly one result on
// the master stream. Points are expected in ascending wavelength order. A query
// at or below the first point returns the first value, at or above the last
// point the last value, and otherwise the linear interpolation between the
// bracketing pair, with the quotient truncated toward zero. A kept search
// pointer walks forward from the previous bracket and restarts from the first
// point when it has overshot. Status reports a query on an empty table or an
// append to a full table (the point is dropped); both give value 0. The block
// takes one request at a time. An interior query takes longer for each point
// the pointer passes (and for a second walk from the first point after an
// overshoot), since the table has a single registered read port, and it
// waits on the bit-serial divider. The table needs no clearing pass after
// reset; only entries below the point count are ever read. A new request is
// taken as soon as the previous result sits in the output register.
module piecewise_linear_resampler_core #(
	parameter int MAX_POINTS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [15:0] wavelength, [39:16] sample_value
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] interp_value
	output logic [1:0]  m_tuser    // [1:0] status
);
	import plr_pkg::*;

	plr_cmd_t cmd;
	plr_sts_t sts;

	// Sequence each request; hold the walk state between steps.
	plr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Store points, compare, multiply, divide and register the result.
	plr_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (s_tuser),
		.in_wl      (s_tdata[WL_W-1:0]),
		.in_val     (s_tdata[WL_W+VAL_W-1:WL_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (m_tuser)
	);

	// An error result always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
		else $error("error result with nonzero value");

	// Status code 3 is never produced.
	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 2'd3))
		else $error("undefined status code");

	// One request in flight: no accept in the cycle after an accept.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

endmodule
